[rtl/core/wbss_pkg.sv]
// Shared constants, codes and types of the wildcard byte signature scanner.
package wbss_pkg;

    localparam int DEF_MAX_PATTERN   = 16;
    localparam int DEF_ADDRESS_WIDTH = 32;

    // Pattern bytes held in the two 64-bit pattern registers
    localparam int PATTERN_REG_BYTES = 16;
    localparam int PAT_IDX_W         = 4;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int LENGTH_W    = 5;
    localparam int OFFSET_W    = 4;
    localparam int MODE_W      = 2;
    localparam int COUNT_W     = 32;
    localparam int OUT_ADDR_W  = 32;

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_LEVEL_W = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd5;

    // Search modes; the unused code behaves as first mode
    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALL   = 2'd2;

    // Result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [8*PATTERN_REG_BYTES-1:0] pattern;
        logic [PATTERN_REG_BYTES-1:0]   care;
        logic [LENGTH_W-1:0]            length;
        logic [OFFSET_W-1:0]            offset;
        logic [MODE_W-1:0]              mode;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        pattern: '0,
        care:    '1,
        length:  LENGTH_W'(1),
        offset:  '0,
        mode:    MODE_FIRST
    };

    typedef struct packed {
        logic                  result_kind;
        logic                  found;
        logic [OUT_ADDR_W-1:0] match_address;
        logic [COUNT_W-1:0]    match_count;
        logic                  last_of_run;
    } result_t;

    // Up to two results written to the output queue in one cycle, item_a first
    typedef struct packed {
        logic [1:0] count;
        result_t    item_a;
        result_t    item_b;
    } push_t;

endpackage

[rtl/core/wbss_ifs.sv]
// Valid/ready channel interfaces for the scanned bytes and the results.
interface wbss_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_region;

    modport source (output valid, data_byte, end_of_region, input ready);
    modport sink   (input valid, data_byte, end_of_region, output ready);
endinterface

interface wbss_result_if;
    import wbss_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  result_kind;
    logic                  found;
    logic [OUT_ADDR_W-1:0] match_address;
    logic [COUNT_W-1:0]    match_count;
    logic                  last_of_run;

    modport source (output valid, result_kind, found, match_address, match_count,
                    last_of_run, input ready);
    modport sink   (input valid, result_kind, found, match_address, match_count,
                    last_of_run, output ready);
endinterface

[rtl/core/wbss_cell.sv]
// One window cell: holds a byte of the window and checks the byte it receives against its pattern byte.
module wbss_cell #(
    parameter int MAX_PATTERN = wbss_pkg::DEF_MAX_PATTERN,
    parameter int AGE         = 0
) (
    input  logic                             clk,
    input  logic                             shift,
    input  logic [7:0]                       byte_in,
    input  logic [$clog2(MAX_PATTERN+1)-1:0] length,
    input  wbss_pkg::cfg_t                   cfg,
    output logic [7:0]                       byte_out,
    output logic                             ok
);
    import wbss_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [7:0]           byte_reg;
    logic [LEN_W-1:0]     idx;
    logic [PAT_IDX_W-1:0] sel;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Byte at this age lines up with pattern byte length-1-AGE
    always_comb
    begin
        idx = length - LEN_W'(AGE) - LEN_W'(1);
        sel = PAT_IDX_W'(idx);
        if (32'(length) <= AGE)
        begin
            ok = 1'b1;
        end
        else if (32'(idx) >= PATTERN_REG_BYTES)
        begin
            ok = 1'b1;
        end
        else if (!cfg.care[sel])
        begin
            ok = 1'b1;
        end
        else
        begin
            ok = (cfg.pattern[8*sel +: 8] == byte_in);
        end
    end

endmodule

[rtl/core/wbss_tracker.sv]
// Region tracker: first and latest match, match count, and result forming.
module wbss_tracker #(
    parameter int ADDRESS_WIDTH = wbss_pkg::DEF_ADDRESS_WIDTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic                     hit,
    input  logic                     eor,
    input  logic [ADDRESS_WIDTH-1:0] start,
    input  wbss_pkg::cfg_t           cfg,
    output wbss_pkg::push_t          push
);
    import wbss_pkg::*;

    logic                     found_reg;
    logic [ADDRESS_WIDTH-1:0] first_reg;
    logic [ADDRESS_WIDTH-1:0] latest_reg;
    logic [COUNT_W-1:0]       matches_reg;

    logic [COUNT_W-1:0]       count_now;
    logic                     found_now;
    logic [ADDRESS_WIDTH-1:0] first_now;
    logic [ADDRESS_WIDTH-1:0] latest_now;
    logic [ADDRESS_WIDTH-1:0] base;
    logic [ADDRESS_WIDTH-1:0] summ_addr;
    logic                     report;
    result_t                  match_item;
    result_t                  summary_item;

    always_comb
    begin
        count_now  = (hit && (matches_reg != '1)) ? matches_reg + COUNT_W'(1) : matches_reg;
        found_now  = found_reg || hit;
        first_now  = (hit && !found_reg) ? start : first_reg;
        latest_now = hit ? start : latest_reg;
        base       = (cfg.mode == MODE_LAST) ? latest_now : first_now;
        summ_addr  = (found_now && (cfg.mode != MODE_ALL))
                   ? base + ADDRESS_WIDTH'(cfg.offset) : '0;
        report     = hit && (cfg.mode == MODE_ALL);

        match_item.result_kind   = KIND_MATCH;
        match_item.found         = 1'b1;
        match_item.match_address = OUT_ADDR_W'(start);
        match_item.match_count   = count_now;
        match_item.last_of_run   = !eor;

        summary_item.result_kind   = KIND_SUMMARY;
        summary_item.found         = found_now;
        summary_item.match_address = OUT_ADDR_W'(summ_addr);
        summary_item.match_count   = count_now;
        summary_item.last_of_run   = 1'b1;

        push.count  = fire ? (2'(report) + 2'(eor)) : 2'd0;
        push.item_a = report ? match_item : summary_item;
        push.item_b = summary_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            first_reg   <= '0;
            latest_reg  <= '0;
            matches_reg <= '0;
        end
        else if (fire)
        begin
            if (eor)
            begin
                found_reg   <= 1'b0;
                first_reg   <= '0;
                latest_reg  <= '0;
                matches_reg <= '0;
            end
            else
            begin
                found_reg   <= found_now;
                first_reg   <= first_now;
                latest_reg  <= latest_now;
                matches_reg <= count_now;
            end
        end
    end

endmodule

[rtl/core/wbss_result_fifo.sv]
// Output queue of results, up to two writes and one read per cycle.
module wbss_result_fifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wbss_pkg::push_t                       push,
    output logic                                  room,
    output logic [wbss_pkg::FIFO_LEVEL_W-1:0]     level,
    wbss_result_if.source                         result
);
    import wbss_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    result_t                 mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]        wr_reg;
    logic [PTR_W-1:0]        rd_reg;
    logic [FIFO_LEVEL_W-1:0] level_reg;
    logic [PTR_W-1:0]        wr_plus1;
    logic                    pop;
    result_t                 head;

    assign wr_plus1 = wr_reg + PTR_W'(1);
    assign pop      = result.valid && result.ready;
    assign room     = (level_reg <= FIFO_LEVEL_W'(FIFO_DEPTH - 2));
    assign level    = level_reg;
    assign head     = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_reg] <= push.item_a;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_plus1] <= push.item_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_reg + PTR_W'(push.count);
            rd_reg    <= rd_reg + PTR_W'(pop);
            level_reg <= level_reg + FIFO_LEVEL_W'(push.count) - FIFO_LEVEL_W'(pop);
        end
    end

    assign result.valid         = (level_reg != '0);
    assign result.result_kind   = head.result_kind;
    assign result.found         = head.found;
    assign result.match_address = head.match_address;
    assign result.match_count   = head.match_count;
    assign result.last_of_run   = head.last_of_run;

endmodule

[rtl/core/wildcard_byte_signature_scanner.sv]
// Top level of the wildcard byte signature scanner.
//
// The scanner takes one byte of a memory region per clock cycle and looks for a
// signature of up to MAX_PATTERN bytes, any of which may be a wildcard through
// the care mask. A row of MAX_PATTERN cells holds the recent bytes; with each
// byte taken, each cell hands its byte to its neighbour and checks the byte it
// sees against the pattern byte that lines up with it at the current length, so
// a match is found the cycle its final byte arrives. First and last modes give
// one summary at the end of the region (start of the first or last match plus
// the offset); all mode reports every match, overlapping ones too, and then a
// summary. Throughput is one byte per cycle, held as long as results are taken;
// a byte that both completes a match in all mode and ends the region yields two
// results, which leave one per cycle while the receiver takes them, through a
// four-entry output queue. A byte's outcome is registered in the match stage,
// then passes through the region tracker into the queue. Configuration is
// written between transactions while the block is idle; the user must keep to
// this, as the block itself does not enforce it.
module wildcard_byte_signature_scanner #(
    parameter int MAX_PATTERN   = wbss_pkg::DEF_MAX_PATTERN,
    parameter int ADDRESS_WIDTH = wbss_pkg::DEF_ADDRESS_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wbss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wbss_pkg::CFG_DATA_W-1:0]  cfg_data,
    wbss_scan_if.sink                        scan,
    wbss_result_if.source                    result
);
    import wbss_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int AW1   = ADDRESS_WIDTH + 1;

    // Configuration registers
    cfg_t cfg_reg;

    // Cell row; the last entry is the byte that falls off the end of the row
    logic [7:0]             win [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] cell_ok;
    logic [LEN_W-1:0]       eff_len;

    // Position in the region and the match stage
    logic [ADDRESS_WIDTH-1:0] pos_reg;
    logic                     s1_valid_reg;
    logic                     s1_hit_reg;
    logic                     s1_eor_reg;
    logic [ADDRESS_WIDTH-1:0] s1_start_reg;

    logic                     scan_acc;
    logic                     s1_fire;
    logic                     pos_ok;
    logic                     hit;
    logic [ADDRESS_WIDTH-1:0] start;

    // Queue side
    push_t                   push;
    logic                    fifo_room;
    logic [FIFO_LEVEL_W-1:0] fifo_level;

    // ------------------------------------------------------------------
    // Configuration: write by index, ignore indexes beyond the list
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  cfg_reg.pattern[CFG_DATA_W-1:0] <= cfg_data;
                REG_PATTERN_HIGH: cfg_reg.pattern[2*CFG_DATA_W-1:CFG_DATA_W] <= cfg_data;
                REG_CARE_MASK:    cfg_reg.care   <= cfg_data[PATTERN_REG_BYTES-1:0];
                REG_LENGTH:       cfg_reg.length <= cfg_data[LENGTH_W-1:0];
                REG_OFFSET:       cfg_reg.offset <= cfg_data[OFFSET_W-1:0];
                REG_MODE:         cfg_reg.mode   <= cfg_data[MODE_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp an overlong length to the row size
    always_comb
    begin
        if (32'(cfg_reg.length) > MAX_PATTERN)
        begin
            eff_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            eff_len = LEN_W'(cfg_reg.length);
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a byte whenever the match stage is free or moves on
    // ------------------------------------------------------------------
    assign s1_fire    = s1_valid_reg && fifo_room;
    assign scan.ready = !s1_valid_reg || fifo_room;
    assign scan_acc   = scan.valid && scan.ready;

    // ------------------------------------------------------------------
    // Cell row: cell k sees the byte of age k, cell 0 the incoming byte
    // ------------------------------------------------------------------
    assign win[0] = scan.data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cell
        wbss_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .AGE         (k)
        ) u_cell (
            .clk      (clk),
            .shift    (scan_acc),
            .byte_in  (win[k]),
            .length   (eff_len),
            .cfg      (cfg_reg),
            .byte_out (win[k+1]),
            .ok       (cell_ok[k])
        );
    end

    // A match needs a non-zero length and may not start before the region
    always_comb
    begin
        pos_ok = ({1'b0, pos_reg} + AW1'(1)) >= AW1'(eff_len);
        hit    = (eff_len != '0) && pos_ok && (&cell_ok);
        start  = pos_reg + ADDRESS_WIDTH'(1) - ADDRESS_WIDTH'(eff_len);
    end

    // Advance the saturating position; drop it back to zero at region end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (scan_acc)
        begin
            if (scan.end_of_region)
            begin
                pos_reg <= '0;
            end
            else if (pos_reg != '1)
            begin
                pos_reg <= pos_reg + ADDRESS_WIDTH'(1);
            end
        end
    end

    // Match stage: hold the outcome of one byte until the queue has room
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            s1_hit_reg   <= hit;
            s1_eor_reg   <= scan.end_of_region;
            s1_start_reg <= start;
        end
    end

    // ------------------------------------------------------------------
    // Region tracker and output queue
    // ------------------------------------------------------------------
    wbss_tracker #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_tracker (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .hit   (s1_hit_reg),
        .eor   (s1_eor_reg),
        .start (s1_start_reg),
        .cfg   (cfg_reg),
        .push  (push)
    );

    wbss_result_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (fifo_room),
        .level  (fifo_level),
        .result (result)
    );

`ifndef SYNTH
    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_acc && scan.end_of_region) |=> (pos_reg == '0))
        else $error("position not cleared after the end of a region");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_level <= FIFO_LEVEL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !fifo_room) |=>
            (s1_valid_reg && $stable(s1_start_reg) && $stable(s1_eor_reg)
             && $stable(s1_hit_reg)))
        else $error("match stage lost a held transaction");
`endif

endmodule

[test/tb_top.sv]
// Self-checking testbench of the wildcard byte signature scanner.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wbss_pkg::*;

    // Longest signature the scanner compares; the window keeps one byte fewer
    localparam int MAX_LEN      = DEF_MAX_PATTERN;
    localparam int WINDOW_DEPTH = MAX_LEN - 1;
    // Cycles to let pass once every report has arrived, to empty the pipeline
    // and for safety before a register write
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 54;
    localparam int DIRECTED_ROWS = 36;
    // Longest random region
    localparam int MAX_REGION    = 40;

    // The spare search mode code, which the scanner treats as first mode
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

    // One row of the directed stimulus: a register write or one scanned byte,
    // optionally with the end-of-region summary typed in
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        logic [7:0]              data_byte;
        logic                    end_of_region;
        logic                    typed;
        result_t                 summary;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    wbss_scan_if   scan_bus ();
    wbss_result_if result_bus ();

    wildcard_byte_signature_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .scan      (scan_bus),
        .result    (result_bus)
    );

    // Shadow copy of the configuration registers, at their reset values
    logic [8*PATTERN_REG_BYTES-1:0] cfg_pattern = '0;
    logic [PATTERN_REG_BYTES-1:0]   cfg_care    = '1;
    logic [LENGTH_W-1:0]            cfg_length  = LENGTH_W'(1);
    logic [OFFSET_W-1:0]            cfg_offset  = '0;
    logic [MODE_W-1:0]              cfg_mode    = MODE_FIRST;

    // Region state of the predictor
    logic [7:0]  window [WINDOW_DEPTH];
    logic [31:0] region_pos;
    bit          seen_any;
    logic [31:0] first_at;
    logic [31:0] latest_at;
    logic [31:0] hit_count;

    // Reports still owed by the scanner, oldest first
    result_t pending_reports [$];

    int failures   = 0;
    int bytes_sent = 0;
    int send_idle  = 37;
    int recv_idle  = 79;

    stim_row_t directed_rows [DIRECTED_ROWS];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_region();
        foreach (window[k])
            window[k] = '0;
        region_pos = '0;
        seen_any   = 1'b0;
        first_at   = '0;
        latest_at  = '0;
        hit_count  = '0;
    endfunction

    // Queue a report behind those already owed
    function automatic void owe_report(result_t rep);
        pending_reports.insert(pending_reports.size(), rep);
    endfunction

    function automatic logic [7:0] pattern_byte(int i);
        return cfg_pattern[8*i +: 8];
    endfunction

    // True when signature byte i takes value v: a cleared care bit, or any
    // byte beyond the pattern registers, is a wildcard
    function automatic bit pattern_accepts(int i, logic [7:0] v);
        if (i >= PATTERN_REG_BYTES)
            return 1'b1;
        if (!cfg_care[i])
            return 1'b1;
        return pattern_byte(i) == v;
    endfunction

    // Work out the reports caused by one scanned byte and queue them
    function automatic void predict_reports(logic [7:0] b, logic eor);
        int          len;
        bit          hit;
        logic [31:0] start;
        logic [31:0] addr;
        result_t     rep;

        hit   = 1'b0;
        start = '0;
        // Clamp an overlong length; zero length never matches
        len = (cfg_length > MAX_LEN) ? MAX_LEN : int'(cfg_length);
        // No match may start before the first byte of the region
        if (len != 0 && longint'(region_pos) + 1 >= len)
        begin
            hit = pattern_accepts(len - 1, b);
            for (int k = 1; hit && k < len; k++)
                hit = pattern_accepts(len - 1 - k, window[k-1]);
            start = region_pos + 1 - len;
        end

        if (hit)
        begin
            if (!seen_any)
            begin
                seen_any = 1'b1;
                first_at = start;
            end
            latest_at = start;
            if (hit_count != '1)
                hit_count++;
            // The mode is read as the report is formed
            if (cfg_mode == MODE_ALL)
            begin
                rep = '{result_kind: KIND_MATCH, found: 1'b1, match_address: start,
                        match_count: hit_count, last_of_run: ~eor};
                owe_report(rep);
            end
        end

        // Shift the window and advance the saturating position
        for (int k = WINDOW_DEPTH - 1; k > 0; k--)
            window[k] = window[k-1];
        window[0] = b;
        if (region_pos != '1)
            region_pos++;

        if (eor)
        begin
            addr = '0;
            if (seen_any && cfg_mode != MODE_ALL)
                addr = ((cfg_mode == MODE_LAST) ? latest_at : first_at) + cfg_offset;
            rep = '{result_kind: KIND_SUMMARY, found: seen_any, match_address: addr,
                    match_count: hit_count, last_of_run: 1'b1};
            owe_report(rep);
            clear_region();
        end
    endfunction

    // ------------------------------------------------------------------
    // Directed rows
    // ------------------------------------------------------------------

    function automatic stim_row_t wr(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row           = '0;
        row.kind      = ROW_WRITE;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic stim_row_t byte_in(logic [7:0] b, logic eor);
        stim_row_t row;
        row               = '0;
        row.kind          = ROW_BYTE;
        row.data_byte     = b;
        row.end_of_region = eor;
        return row;
    endfunction

    // Final byte of a region with the summary it must give
    function automatic stim_row_t region_end(logic [7:0] b, logic fnd,
                                             logic [31:0] addr, logic [31:0] cnt);
        stim_row_t row;
        row         = byte_in(b, 1'b1);
        row.typed   = 1'b1;
        row.summary = '{result_kind: KIND_SUMMARY, found: fnd, match_address: addr,
                        match_count: cnt, last_of_run: 1'b1};
        return row;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte at a falling edge, hold it until the transaction
    // completes, then predict. Valid stays high for a following byte.
    task automatic send_byte(logic [7:0] b, logic eor);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            scan_bus.valid <= 1'b0;
            @(negedge clk);
        end
        scan_bus.valid         <= 1'b1;
        scan_bus.data_byte     <= b;
        scan_bus.end_of_region <= eor;
        do
            @(posedge clk);
        while (!scan_bus.ready);
        predict_reports(b, eor);
        bytes_sent++;
    endtask

    // Stop sending, wait for every owed report, then let the pipeline empty
    // of bytes that cause none
    task automatic settle();
        @(negedge clk);
        scan_bus.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write one register; the shadow copy follows at the writing edge
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_PATTERN_LOW:  cfg_pattern[63:0]   = val;
            REG_PATTERN_HIGH: cfg_pattern[127:64] = val;
            REG_CARE_MASK:    cfg_care            = val[PATTERN_REG_BYTES-1:0];
            REG_LENGTH:       cfg_length          = val[LENGTH_W-1:0];
            REG_OFFSET:       cfg_offset          = val[OFFSET_W-1:0];
            REG_MODE:         cfg_mode            = val[MODE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock, receiver, checker, watchdog
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result side at random, at the falling edge
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_bus.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare each accepted report with the oldest one owed
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with none owed: kind %0d address 0x%0h count %0d",
                       result_bus.result_kind, result_bus.match_address,
                       result_bus.match_count);
                failures++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("result_kind", want.result_kind, result_bus.result_kind);
                check_field("found", want.found, result_bus.found);
                check_field("match_address", want.match_address, result_bus.match_address);
                check_field("match_count", want.match_count, result_bus.match_count);
                check_field("last_of_run", want.last_of_run, result_bus.last_of_run);
            end
        end
    end

    // Abandon a run that hangs; far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("wildcard_byte_signature_scanner test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        int                             phase_end;
        int                             rlen;
        int                             eff;
        int                             at;
        int                             spot;
        int                             implants;
        bit                             tight;
        logic [7:0]                     tight_a;
        logic [7:0]                     tight_b;
        logic [8*PATTERN_REG_BYTES-1:0] new_pattern;
        logic [PATTERN_REG_BYTES-1:0]   new_care;
        logic [LENGTH_W-1:0]            new_length;
        logic [OFFSET_W-1:0]            new_offset;
        logic [7:0]                     region_buf [MAX_REGION];

        // Drive every input to a known value and hold reset
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        scan_bus.valid         = 1'b0;
        scan_bus.data_byte     = '0;
        scan_bus.end_of_region = 1'b0;
        clear_region();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_rows = '{
            // reset pattern is a single zero byte that must match
            region_end(8'h00, 1'b1, 32'd0, 32'd1),
            region_end(8'hFF, 1'b0, 32'd0, 32'd0),
            // four byte signature, last mode, largest offset
            wr(REG_PATTERN_LOW, 64'hFFEE_DDCC_4433_2211),
            wr(REG_PATTERN_HIGH, 64'h00FF_00FF_00FF_00FF),
            wr(REG_CARE_MASK, 64'h0000_0000_0000_F00F),
            wr(REG_LENGTH, 64'd4),
            wr(REG_OFFSET, 64'd15),
            wr(REG_MODE, 64'(MODE_LAST)),
            byte_in(8'h11, 1'b0), byte_in(8'h22, 1'b0),
            byte_in(8'h33, 1'b0), byte_in(8'h44, 1'b0),
            byte_in(8'h11, 1'b0), byte_in(8'h22, 1'b0),
            byte_in(8'h33, 1'b0),
            region_end(8'h44, 1'b1, 32'd19, 32'd2),
            // leading wildcard must not reach before the region start
            wr(REG_CARE_MASK, 64'h0000_0000_0000_000E),
            byte_in(8'h22, 1'b0), byte_in(8'h33, 1'b0),
            region_end(8'h44, 1'b0, 32'd0, 32'd0),
            // all mode, all wildcards: overlapping matches, two reports at the end
            wr(REG_MODE, 64'(MODE_ALL)),
            wr(REG_LENGTH, 64'd2),
            wr(REG_CARE_MASK, 64'd0),
            byte_in(8'h00, 1'b0), byte_in(8'hFF, 1'b0), byte_in(8'h80, 1'b1),
            // zero length never matches
            wr(REG_LENGTH, 64'd0),
            region_end(8'h5A, 1'b0, 32'd0, 32'd0),
            // spare mode behaves as first mode
            wr(REG_MODE, 64'(MODE_SPARE)),
            wr(REG_LENGTH, 64'd1),
            wr(REG_CARE_MASK, 64'h0000_0000_0000_FFFF),
            region_end(8'h11, 1'b1, 32'd15, 32'd1),
            // overlong length is clamped to the full window
            wr(REG_LENGTH, 64'd31),
            wr(REG_CARE_MASK, 64'd0),
            byte_in(8'hA5, 1'b0),
            region_end(8'h5A, 1'b0, 32'd0, 32'd0)
        };

        // Walk the directed rows; write registers only once the scanner is idle
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                send_byte(directed_rows[i].data_byte, directed_rows[i].end_of_region);
                // swap in the hand-written summary for this byte
                if (directed_rows[i].typed)
                    pending_reports[pending_reports.size()-1] = directed_rows[i].summary;
            end
        end

        // Random phases: a fresh setting each phase, then regions that mostly
        // carry the signature, some of them truncated or corrupted. A phase
        // may stop part-way through a region, so the next setting lands
        // mid-region.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // sender 37 / receiver 79, then swapped, then no idling
            send_idle = (phase < 4) ? 37 : (phase < 8) ? 79 : 0;
            recv_idle = (phase < 4) ? 79 : (phase < 8) ? 37 : 0;

            settle();
            tight   = $urandom_range(1);
            tight_a = 8'($urandom);
            tight_b = tight_a ^ (8'h01 << $urandom_range(7));
            for (int i = 0; i < PATTERN_REG_BYTES; i++)
                new_pattern[8*i +: 8] = tight ? ($urandom_range(1) ? tight_a : tight_b)
                                              : 8'($urandom);
            case ($urandom_range(7))
                0:       new_care = '0;
                1:       new_care = '1;
                default: new_care = PATTERN_REG_BYTES'($urandom | $urandom);
            endcase
            case ($urandom_range(19))
                0:       new_length = '0;
                1:       new_length = LENGTH_W'(MAX_LEN);
                2:       new_length = LENGTH_W'($urandom_range(MAX_LEN + 1,
                                                               (1 << LENGTH_W) - 1));
                3:       new_length = LENGTH_W'(1);
                default: new_length = LENGTH_W'($urandom_range(2, 8));
            endcase
            case ($urandom_range(3))
                0:       new_offset = '0;
                1:       new_offset = '1;
                default: new_offset = OFFSET_W'($urandom);
            endcase
            write_reg(REG_PATTERN_LOW, new_pattern[63:0]);
            write_reg(REG_PATTERN_HIGH, new_pattern[127:64]);
            write_reg(REG_CARE_MASK, 64'(new_care));
            write_reg(REG_LENGTH, 64'(new_length));
            write_reg(REG_OFFSET, 64'(new_offset));
            write_reg(REG_MODE, 64'(MODE_W'($urandom_range(3))));

            phase_end = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < phase_end)
            begin
                eff  = (cfg_length > MAX_LEN) ? MAX_LEN : int'(cfg_length);
                rlen = ($urandom_range(9) == 0) ? $urandom_range(25, MAX_REGION)
                                                : $urandom_range(1, 20);
                // filler: the narrow alphabet breeds overlapping matches
                for (int i = 0; i < rlen; i++)
                begin
                    if (tight)
                        region_buf[i] = $urandom_range(1) ? tight_a : tight_b;
                    else if ($urandom_range(3) == 0)
                        region_buf[i] = pattern_byte($urandom_range(15));
                    else
                        region_buf[i] = 8'($urandom);
                end
                // plant signature copies, wildcards filled at random
                implants = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 3);
                for (int m = 0; m < implants; m++)
                begin
                    at = (rlen > eff && $urandom_range(3) != 0) ? $urandom_range(rlen - eff)
                                                                : $urandom_range(rlen - 1);
                    for (int j = 0; j < eff && at + j < rlen; j++)
                        region_buf[at+j] = cfg_care[j] ? pattern_byte(j) : 8'($urandom);
                    // break one copy now and then
                    if (eff > 0 && $urandom_range(4) == 0)
                    begin
                        spot = at + $urandom_range(eff - 1);
                        if (spot < rlen)
                            region_buf[spot] ^= 8'h01 << $urandom_range(7);
                    end
                end
                for (int i = 0; i < rlen && bytes_sent < phase_end; i++)
                    send_byte(region_buf[i], i == rlen - 1);
                // hold off now and then until every owed report is in
                if ($urandom_range(299) == 0)
                    settle();
            end
        end

        // Drain every owed report, then allow a few cycles for strays
        settle();

        if (failures == 0)
            $display("wildcard_byte_signature_scanner test passed");
        else
            $display("wildcard_byte_signature_scanner test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/wbss_pkg.sv
rtl/core/wbss_ifs.sv
rtl/core/wbss_cell.sv
rtl/core/wbss_tracker.sv
rtl/core/wbss_result_fifo.sv
rtl/core/wildcard_byte_signature_scanner.sv
test/tb_top.sv
